FILE: hdl/ifrp_pkg.sv
package ifrp_pkg;

    localparam int WORD_W          = 32;
    localparam int NUM_GROUPS      = 3;
    localparam int WORDS_PER_GROUP = 3;
    localparam int NUM_WORDS       = NUM_GROUPS * WORDS_PER_GROUP;

    localparam logic [15:0] ID_ACCEL = 16'h8801;
    localparam logic [15:0] ID_GYRO  = 16'h8C01;
    localparam logic [15:0] ID_EULER = 16'hB001;

    localparam logic [7:0] HDR_BYTE0 = 8'h41;  // 'A'
    localparam logic [7:0] HDR_BYTE1 = 8'h78;  // 'x'
    localparam logic [7:0] TAIL_BYTE = 8'h6D;  // 'm'

    localparam int FRAME_MIN_BYTES = 8;
    localparam int WALK_START      = 6;
    localparam int REC_WORD_FIRST  = 3;
    localparam int REC_WORD_LAST   = 14;
    localparam int REC_SKIP_AT     = 12;
    localparam int REC_KNOWN_LEN   = 15;
    localparam int REC_UNKNOWN_LEN = 13;
    localparam int REC_CONFIRM_AT  = 16;

    typedef enum logic [1:0] {
        GRP_NONE  = 2'd0,
        GRP_ACCEL = 2'd1,
        GRP_GYRO  = 2'd2,
        GRP_EULER = 2'd3
    } t_group;

    typedef enum logic [1:0] {
        ST_UPDATED   = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_NO_DATA   = 2'd2
    } t_status;

    typedef struct packed {
        logic [NUM_GROUPS-1:0]            touched;
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    } t_shadow;

    function automatic t_group group_of(input logic [15:0] id);
        t_group g;
        case (id)
            ID_ACCEL: g = GRP_ACCEL;
            ID_GYRO:  g = GRP_GYRO;
            ID_EULER: g = GRP_EULER;
            default:  g = GRP_NONE;
        endcase
        return g;
    endfunction

endpackage

FILE: hdl/ifrp_walk.sv
module ifrp_walk #(
    parameter int POS_W = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_clear,
    input  logic [POS_W-1:0]        i_pos,
    input  logic [7:0]              i_byte,
    output ifrp_pkg::t_shadow       o_shadow
);
    import ifrp_pkg::*;

    logic [POS_W-1:0]                       r_start, n_start;
    logic [7:0]                             r_id_lo, n_id_lo;
    t_group                                 r_group, n_group;
    logic [POS_W-1:0]                       r_pend_start, n_pend_start;
    t_group                                 r_pend_group, n_pend_group;
    logic [WORDS_PER_GROUP-1:0][WORD_W-1:0] r_pend_words, n_pend_words;
    logic [NUM_GROUPS-1:0]                  r_touched, n_touched;
    logic [NUM_WORDS-1:0][WORD_W-1:0]       r_words, n_words;

    logic [POS_W-1:0] s;
    logic [POS_W-1:0] q;
    logic [1:0]       conf_idx;
    logic             confirm;

    always_comb begin
        s            = r_start;
        q            = i_pos - (s + POS_W'(REC_WORD_FIRST));
        conf_idx     = 2'(r_pend_group) - 2'd1;
        confirm      = (r_pend_group != GRP_NONE) &&
                       (i_pos == r_pend_start + POS_W'(REC_CONFIRM_AT));
        n_start      = r_start;
        n_id_lo      = r_id_lo;
        n_group      = r_group;
        n_pend_start = r_pend_start;
        n_pend_group = r_pend_group;
        n_pend_words = r_pend_words;
        n_touched    = r_touched;
        n_words      = r_words;
        if (i_step) begin
            if (confirm) begin
                for (int j = 0; j < NUM_GROUPS; j++) begin
                    if (conf_idx == 2'(j)) begin
                        for (int k = 0; k < WORDS_PER_GROUP; k++) begin
                            n_words[j*WORDS_PER_GROUP + k] = r_pend_words[k];
                        end
                        n_touched[j] = 1'b1;
                    end
                end
                n_pend_group = GRP_NONE;
            end
            if (i_pos == s) begin
                n_id_lo = i_byte;
            end else if (i_pos == s + POS_W'(1)) begin
                n_group = group_of({i_byte, r_id_lo});
            end else if (r_group != GRP_NONE &&
                         i_pos >= s + POS_W'(REC_WORD_FIRST) &&
                         i_pos <= s + POS_W'(REC_WORD_LAST)) begin
                if (q[3:2] < 2'(WORDS_PER_GROUP)) begin
                    n_pend_words[q[3:2]][{q[1:0], 3'b000} +: 8] = i_byte;
                end
                if (i_pos == s + POS_W'(REC_WORD_LAST)) begin
                    n_pend_start = s;
                    n_pend_group = r_group;
                    n_group      = GRP_NONE;
                    n_start      = s + POS_W'(REC_KNOWN_LEN);
                end
            end else if (r_group == GRP_NONE && i_pos == s + POS_W'(REC_SKIP_AT)) begin
                n_pend_start = s;
                n_pend_group = GRP_NONE;
                n_start      = s + POS_W'(REC_UNKNOWN_LEN);
            end
        end
        o_shadow = '{touched: n_touched, words: n_words};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= POS_W'(WALK_START);
            r_group      <= GRP_NONE;
            r_pend_group <= GRP_NONE;
            r_touched    <= '0;
        end else if (i_clear) begin
            r_start      <= POS_W'(WALK_START);
            r_group      <= GRP_NONE;
            r_pend_group <= GRP_NONE;
            r_touched    <= '0;
        end else begin
            r_start      <= n_start;
            r_group      <= n_group;
            r_pend_group <= n_pend_group;
            r_touched    <= n_touched;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id_lo      <= n_id_lo;
        r_pend_start <= n_pend_start;
        r_pend_words <= n_pend_words;
        r_words      <= n_words;
    end

endmodule

FILE: hdl/imu_frame_record_parser.sv
// IMU frame record parser. Takes one frame byte per beat, frame_end set on the
// last byte, and returns one result per frame in the result register after its
// last byte leaves the input register. A byte is accepted every cycle unless a
// last byte waits on an unread result: record walk, header/tail check and commit
// are combinational between the input and result registers, and the result
// register lets the next frame stream in while a result waits. A frame is
// malformed (status 1) if shorter than 8 bytes, longer than MAX_FRAME_BYTES, not
// opening with "Ax" or not closing with 'm'. Records start at offset 6; accel,
// gyro and Euler records carry three raw 32-bit little-endian words and commit
// only if the frame is good and reaches record offset 16. A good frame with no
// commit is status 2; outputs hold latest committed words, updated-frame count.
module imu_frame_record_parser #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_sample_number,
    output logic [31:0] o_accel_x,
    output logic [31:0] o_accel_y,
    output logic [31:0] o_accel_z,
    output logic [31:0] o_gyro_x,
    output logic [31:0] o_gyro_y,
    output logic [31:0] o_gyro_z,
    output logic [31:0] o_angle_roll,
    output logic [31:0] o_angle_pitch,
    output logic [31:0] o_angle_yaw
);
    import ifrp_pkg::*;

    localparam int               POS_W   = $clog2(MAX_FRAME_BYTES + 32);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic                             r_in_valid;
    logic [7:0]                       r_in_byte;
    logic                             r_in_end;

    logic [POS_W-1:0]                 r_pos;
    logic                             r_hdr_good;
    logic                             r_stopped;
    logic [NUM_WORDS-1:0][WORD_W-1:0] r_latest, n_latest;
    logic [WORD_W-1:0]                r_count, n_count;

    logic                             r_out_valid;
    t_status                          r_out_status;
    logic [WORD_W-1:0]                r_out_count;
    logic [NUM_WORDS-1:0][WORD_W-1:0] r_out_words;

    logic    adv;
    logic    in_range;
    logic    n_hdr_good;
    logic    n_stopped;
    logic    malformed;
    t_status status;
    t_shadow shadow;

    assign adv        = r_in_valid && (!r_in_end || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_range   = r_pos < POS_MAX;

    ifrp_walk #(
        .POS_W (POS_W)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv && in_range),
        .i_clear  (adv && r_in_end),
        .i_pos    (r_pos),
        .i_byte   (r_in_byte),
        .o_shadow (shadow)
    );

    always_comb begin
        n_hdr_good = r_hdr_good;
        if (in_range) begin
            if (r_pos == '0) begin
                n_hdr_good = (r_in_byte == HDR_BYTE0);
            end else if (r_pos == POS_W'(1)) begin
                n_hdr_good = r_hdr_good && (r_in_byte == HDR_BYTE1);
            end
        end
        n_stopped = r_stopped || !in_range;
        malformed = n_stopped || !n_hdr_good || (r_in_byte != TAIL_BYTE) ||
                    ((r_pos + POS_W'(1)) < POS_W'(FRAME_MIN_BYTES));
        n_latest  = r_latest;
        n_count   = r_count;
        if (malformed) begin
            status = ST_MALFORMED;
        end else if (shadow.touched != '0) begin
            status  = ST_UPDATED;
            n_count = r_count + WORD_W'(1);
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (shadow.touched[k / WORDS_PER_GROUP]) begin
                    n_latest[k] = shadow.words[k];
                end
            end
        end else begin
            status = ST_NO_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hdr_good <= 1'b0;
            r_stopped  <= 1'b0;
            r_latest   <= '0;
            r_count    <= '0;
        end else if (adv) begin
            if (r_in_end) begin
                r_pos      <= '0;
                r_hdr_good <= 1'b0;
                r_stopped  <= 1'b0;
                r_latest   <= n_latest;
                r_count    <= n_count;
            end else begin
                r_pos      <= in_range ? r_pos + POS_W'(1) : r_pos;
                r_hdr_good <= n_hdr_good;
                r_stopped  <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_end) begin
            r_out_status <= status;
            r_out_count  <= n_count;
            r_out_words  <= n_latest;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = 2'(r_out_status);
    assign o_sample_number = r_out_count;
    assign o_accel_x       = r_out_words[0];
    assign o_accel_y       = r_out_words[1];
    assign o_accel_z       = r_out_words[2];
    assign o_gyro_x        = r_out_words[3];
    assign o_gyro_y        = r_out_words[4];
    assign o_gyro_z        = r_out_words[5];
    assign o_angle_roll    = r_out_words[6];
    assign o_angle_pitch   = r_out_words[7];
    assign o_angle_yaw     = r_out_words[8];

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position past frame limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_end) |=> (r_pos == '0 && r_out_valid && !r_stopped))
        else $error("frame end did not restart the frame and present a result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_end && status == ST_UPDATED) |=> (r_count == $past(r_count) + 32'd1))
        else $error("updated frame did not advance the sample count");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !(r_in_end && status == ST_UPDATED)) |=> $stable(r_count))
        else $error("sample count moved without an updated frame");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import ifrp_pkg::*;

    localparam int FRAME_LIMIT = 4096;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 1550;

    typedef struct packed {
        t_status                          status;
        logic [31:0]                      count;
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    } t_imu_result;

    class imu_frame_scoreboard;
        int unsigned pos;
        bit          hdr_ok;
        int unsigned rec_at;
        logic [7:0]  id_lo;
        t_group      rec_grp;
        int unsigned conf_at;
        t_group      conf_grp;
        logic [31:0] cap_words[3];
        logic [31:0] stage_words[NUM_WORDS];
        logic [2:0]  stage_hit;
        bit          overrun;
        logic [31:0] held_words[NUM_WORDS];
        logic [31:0] good_frames;
        t_imu_result expected_results[$];
        int          errors;
        string       word_name[NUM_WORDS];

        function new();
            word_name = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z",
                          "angle_roll", "angle_pitch", "angle_yaw"};
            foreach (held_words[k]) held_words[k] = '0;
            good_frames = '0;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos = 0;
            hdr_ok = 1'b0;
            rec_at = WALK_START;
            id_lo = '0;
            rec_grp = GRP_NONE;
            conf_at = 0;
            conf_grp = GRP_NONE;
            foreach (cap_words[k]) cap_words[k] = '0;
            foreach (stage_words[k]) stage_words[k] = '0;
            stage_hit = '0;
            overrun = 1'b0;
        endfunction

        function void walk(int unsigned p, logic [7:0] b);
            int unsigned s;
            int unsigned q;
            int unsigned g;
            s = rec_at;
            if (conf_grp != GRP_NONE && p == conf_at + REC_CONFIRM_AT) begin
                g = int'(conf_grp) - 1;
                for (int k = 0; k < WORDS_PER_GROUP; k++)
                    stage_words[g * WORDS_PER_GROUP + k] = cap_words[k];
                stage_hit[g] = 1'b1;
                conf_grp = GRP_NONE;
            end
            if (p == s) begin
                id_lo = b;
            end else if (p == s + 1) begin
                case ({b, id_lo})
                    ID_ACCEL: rec_grp = GRP_ACCEL;
                    ID_GYRO:  rec_grp = GRP_GYRO;
                    ID_EULER: rec_grp = GRP_EULER;
                    default:  rec_grp = GRP_NONE;
                endcase
            end else if (rec_grp != GRP_NONE && p >= s + REC_WORD_FIRST
                         && p <= s + REC_WORD_LAST) begin
                q = p - (s + REC_WORD_FIRST);
                cap_words[q / 4][8 * (q % 4) +: 8] = b;
                if (p == s + REC_WORD_LAST) begin
                    conf_at = s;
                    conf_grp = rec_grp;
                    rec_grp = GRP_NONE;
                    rec_at = s + REC_KNOWN_LEN;
                end
            end else if (rec_grp == GRP_NONE && p == s + REC_SKIP_AT) begin
                conf_at = s;
                conf_grp = GRP_NONE;
                rec_at = s + REC_UNKNOWN_LEN;
            end
        endfunction

        function void note_beat(logic [7:0] b, logic last);
            int unsigned p;
            t_imu_result r;
            p = pos;
            if (p >= FRAME_LIMIT) begin
                overrun = 1'b1;
            end else begin
                if (p == 0) hdr_ok = (b == HDR_BYTE0);
                else if (p == 1) hdr_ok = hdr_ok && (b == HDR_BYTE1);
                walk(p, b);
                pos = p + 1;
            end
            if (!last) return;
            if (overrun || p + 1 < FRAME_MIN_BYTES || !hdr_ok || b != TAIL_BYTE) begin
                r.status = ST_MALFORMED;
            end else if (|stage_hit) begin
                for (int k = 0; k < NUM_WORDS; k++)
                    if (stage_hit[k / WORDS_PER_GROUP]) held_words[k] = stage_words[k];
                good_frames = good_frames + 1;
                r.status = ST_UPDATED;
            end else begin
                r.status = ST_NO_DATA;
            end
            r.count = good_frames;
            for (int k = 0; k < NUM_WORDS; k++) r.words[k] = held_words[k];
            expected_results.push_back(r);
            clear_frame();
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void check_result(t_imu_result got);
            t_imu_result want;
            if (expected_results.size() == 0) begin
                fail("result beat with no frame outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                fail($sformatf("status: expected %0d, got %0d", want.status, got.status));
            if (got.count !== want.count)
                fail($sformatf("sample_number: expected %h, got %h", want.count, got.count));
            for (int k = 0; k < NUM_WORDS; k++)
                if (got.words[k] !== want.words[k])
                    fail($sformatf("%s: expected %h, got %h", word_name[k],
                                   want.words[k], got.words[k]));
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [31:0] o_sample_number;
    logic [31:0] o_accel_x, o_accel_y, o_accel_z;
    logic [31:0] o_gyro_x, o_gyro_y, o_gyro_z;
    logic [31:0] o_angle_roll, o_angle_pitch, o_angle_yaw;

    imu_frame_record_parser #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_sample_number(o_sample_number),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z),
        .o_gyro_x       (o_gyro_x),
        .o_gyro_y       (o_gyro_y),
        .o_gyro_z       (o_gyro_z),
        .o_angle_roll   (o_angle_roll),
        .o_angle_pitch  (o_angle_pitch),
        .o_angle_yaw    (o_angle_yaw)
    );

    imu_frame_scoreboard sb = new();

    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    int          out_hold_cycles = 0;
    int          out_stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    logic [7:0]  frame_bytes[$];

    always #6 i_clk = ~i_clk;

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls plus an optional long hold-off
    initial begin
        t_imu_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.status = t_status'(o_status);
                got.count = o_sample_number;
                got.words = {o_angle_yaw, o_angle_pitch, o_angle_roll,
                             o_gyro_z, o_gyro_y, o_gyro_x,
                             o_accel_z, o_accel_y, o_accel_x};
                sb.check_result(got);
            end
            if (out_hold_cycles > 0) begin
                out_hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (out_stall_left > 0) begin
                out_stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                out_stall_left = pick_gap(out_idle_on);
            end
        end
    end

    task automatic put_beat(logic [7:0] b, logic last);
        int gap;
        gap = pick_gap(in_idle_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) put_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes = {};
    endtask

    function automatic logic [7:0] fill_byte(int fill);
        if (fill == 1) return 8'h00;
        if (fill == 2) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_id();
        logic [15:0] id;
        case ($urandom_range(0, 4))
            0: id = ID_ACCEL;
            1: id = ID_GYRO;
            2: id = ID_EULER;
            default: begin
                id = 16'($urandom);
                if (id == ID_ACCEL || id == ID_GYRO || id == ID_EULER) id ^= 16'h0100;
            end
        endcase
        return id;
    endfunction

    task automatic add_record(logic [15:0] id, int fill);
        bit known;
        known = (id == ID_ACCEL || id == ID_GYRO || id == ID_EULER);
        frame_bytes.push_back(id[7:0]);
        frame_bytes.push_back(id[15:8]);
        repeat (known ? 13 : 11) frame_bytes.push_back(fill_byte(fill));
    endtask

    task automatic start_frame();
        frame_bytes = {};
        frame_bytes.push_back(HDR_BYTE0);
        frame_bytes.push_back(HDR_BYTE1);
        repeat (4) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic end_frame(int pad);
        repeat (pad) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(TAIL_BYTE);
    endtask

    function automatic logic [7:0] other_than(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == avoid) b = ~b;
        return b;
    endfunction

    task automatic send_random_frame(int max_records);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 94) begin
            start_frame();
            n = $urandom_range(0, max_records);
            repeat (n) add_record(pick_id(), ($urandom_range(0, 9) == 0) ? 1 + $urandom_range(0, 1) : 0);
            end_frame(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
            if (r >= 70 && r < 76) frame_bytes[0] = other_than(HDR_BYTE0);
            else if (r >= 76 && r < 82) frame_bytes[1] = other_than(HDR_BYTE1);
            else if (r >= 82 && r < 88) frame_bytes[frame_bytes.size() - 1] = other_than(TAIL_BYTE);
            else if (r >= 88) begin
                n = $urandom_range(1, 7);
                while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
                if ($urandom_range(0, 1)) frame_bytes[n - 1] = TAIL_BYTE;
            end
        end else begin
            frame_bytes = {};
            repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    initial begin
        int frames;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        frame_bytes = {TAIL_BYTE};
        send_frame();
        start_frame();
        frame_bytes.push_back(TAIL_BYTE);
        send_frame();
        start_frame();
        end_frame(1);
        send_frame();
        start_frame();
        add_record(ID_ACCEL, 1);
        end_frame(1);
        send_frame();
        start_frame();
        add_record(ID_GYRO, 2);
        end_frame(1);
        send_frame();
        start_frame();
        add_record(ID_EULER, 0);
        end_frame(2);
        send_frame();
        start_frame();
        add_record(ID_ACCEL, 0);
        add_record(16'h0188, 0);
        add_record(ID_GYRO, 0);
        add_record(16'h8802, 0);
        add_record(ID_EULER, 0);
        end_frame(3);
        send_frame();
        start_frame();
        add_record(ID_ACCEL, 2);
        add_record(ID_ACCEL, 0);
        end_frame(1);
        send_frame();
        start_frame();
        add_record(ID_GYRO, 0);
        end_frame(0);
        send_frame();
        start_frame();
        add_record(ID_EULER, 0);
        end_frame(1);
        frame_bytes[frame_bytes.size() - 1] = 8'hFF;
        send_frame();
        start_frame();
        add_record(ID_ACCEL, 0);
        end_frame(1);
        frame_bytes[0] = 8'h00;
        send_frame();
        start_frame();
        add_record(ID_GYRO, 0);
        end_frame(1);
        frame_bytes[1] = 8'hFF;
        send_frame();
        start_frame();
        add_record(16'h1234, 0);
        add_record(16'hFFFF, 0);
        end_frame(2);
        send_frame();

        // result side held off while short frames keep coming
        out_hold_cycles = 600;
        in_idle_on = 1'b0;
        repeat (40) send_random_frame(1);

        frames = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (frames % 8 == 0) begin
                in_idle_on = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_frame(4);
            frames++;
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
